// ===== rtl/sei_pkg.sv =====
// Shared types and constants for the SEI user-data-unregistered NAL writer.
// Item structs, register index codes and byte codes; no dependencies.
package sei_pkg;

  localparam int MAX_PAYLOAD = 4096;
  localparam int LEN_W       = 13;
  localparam int UUID_BYTES  = 16;
  localparam int SIZE_RUN    = 255;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_BYTE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CFG_START_CODE_MODE = 2'd0,
    CFG_UUID_HIGH       = 2'd1,
    CFG_UUID_LOW        = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] BYTE_ZERO       = 8'h00;
  localparam logic [7:0] BYTE_START_LAST = 8'h01;
  localparam logic [7:0] BYTE_EPB        = 8'h03;
  localparam logic [7:0] BYTE_NAL_SEI    = 8'h06;
  localparam logic [7:0] BYTE_PT_UDU     = 8'h05;
  localparam logic [7:0] BYTE_FF         = 8'hFF;
  localparam logic [7:0] BYTE_STOP       = 8'h80;

  typedef struct packed {
    logic             kind;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_packet;
  } out_item_t;

  typedef struct packed {
    logic        start_code_mode;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

  typedef struct packed {
    logic busy;
    logic open;
  } seq_stat_t;

endpackage

// ===== rtl/sei_nal_unit_writer_top.sv =====
// SEI user-data-unregistered NAL writer, top level: configuration registers,
// byte sequencer and output register. Depends on sei_pkg, sei_seq, sei_obuf.
//
// Usage:
//   in_*  : items, accepted when in_valid is high and in_stall low. A start
//           item (kind 0) opens a packet of payload_length bytes (capped at
//           MAX_PAYLOAD); byte items (kind 1) carry payload bytes. Byte items
//           with no open packet are dropped; a start item abandons an open one.
//   out_* : framed Annex B bytes, one per handshake; last_of_packet marks the
//           closing 0x80.
//   cfg_* : register writes (start code mode, UUID high, UUID low); always
//           ready, write only while the block is idle.
// Timing: the sequencer registers a taken item; its first byte then passes
// the output register to out_*. The sequencer emits one byte per cycle while
// the output register takes it; an item holds the input until all its bytes
// are out: a payload byte makes 1, with an emulation byte or the tail up to
// 4, a start item 22 to 39 (start code, header, size run, UUID, tail). The
// next item is taken in the cycle the current one's last byte is emitted.
// Stall: when out_stall holds the output register full, the sequencer and
// with it the input stall. Reset clears control state and closes any packet.
module sei_nal_unit_writer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sei_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sei_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import sei_pkg::*;

  cfg_t      cfg_r;
  emit_t     emit;
  logic      emit_ready;
  seq_stat_t seq_stat;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_CODE_MODE: cfg_r.start_code_mode <= cfg_data[0];
        CFG_UUID_HIGH:       cfg_r.uuid_high       <= cfg_data;
        CFG_UUID_LOW:        cfg_r.uuid_low        <= cfg_data;
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  // walk the bytes of the held item, one per cycle while the output takes them
  sei_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .cfg        (cfg_r),
    .emit       (emit),
    .emit_ready (emit_ready),
    .stat       (seq_stat)
  );

  // hold the current byte while the receiver stalls
  sei_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .emit_ready (emit_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

`ifndef SYNTHESIS
  // the packet closes only with the stop byte
  a_last_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_of_packet |-> out_item.out_byte == BYTE_STOP)
    else $error("last_of_packet on a byte other than 0x80");

  // an idle sequencer never stalls the input
  a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !seq_stat.busy |-> !in_stall)
    else $error("input stalled while sequencer idle");

  // bytes are only produced inside an open packet
  a_busy_open: assert property (@(posedge clk) disable iff (!rst_n)
    seq_stat.busy |-> seq_stat.open)
    else $error("sequencer busy with no open packet");
`endif

endmodule

// ===== rtl/sei_seq.sv =====
// Item register and byte sequencer: walks header, payload and tail bytes.
// Depends on sei_pkg.
module sei_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sei_pkg::in_item_t  in_item,
  input  sei_pkg::cfg_t      cfg,
  output sei_pkg::emit_t     emit,
  input  logic               emit_ready,
  output sei_pkg::seq_stat_t stat
);
  import sei_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SC,
    PH_NAL,
    PH_PT,
    PH_SIZE,
    PH_UUID,
    PH_EPB,
    PH_DATA,
    PH_TAIL0,
    PH_TAIL80
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]       zero_run_r, zero_run_nxt;
  logic             parity_r, parity_nxt;
  logic             open_r, open_nxt;
  logic [7:0]       byte_r, byte_nxt;

  logic             fire;
  logic             free;
  logic             accept;
  logic [127:0]     uuid_all;
  logic [LEN_W-1:0] len_sat;

  assign uuid_all = {cfg.uuid_high, cfg.uuid_low};
  assign fire     = (phase_r != PH_IDLE) && emit_ready;
  assign len_sat  = (in_item.payload_length > LEN_W'(MAX_PAYLOAD)) ?
                    LEN_W'(MAX_PAYLOAD) : in_item.payload_length;

  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    bytes_left_nxt = bytes_left_r;
    zero_run_nxt   = zero_run_r;
    parity_nxt     = parity_r;
    open_nxt       = open_r;
    byte_nxt       = byte_r;
    emit.valid               = (phase_r != PH_IDLE);
    emit.item.out_byte       = BYTE_ZERO;
    emit.item.last_of_packet = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
      end
      PH_SC: begin
        emit.item.out_byte = (cnt_r == 4'd3) ? BYTE_START_LAST : BYTE_ZERO;
        if (fire) begin
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd3) begin
            phase_nxt = PH_NAL;
          end
        end
      end
      PH_NAL: begin
        emit.item.out_byte = BYTE_NAL_SEI;
        if (fire) begin
          parity_nxt = ~parity_r;
          phase_nxt  = PH_PT;
        end
      end
      PH_PT: begin
        emit.item.out_byte = BYTE_PT_UDU;
        if (fire) begin
          parity_nxt = ~parity_r;
          phase_nxt  = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (rem_r >= LEN_W'(SIZE_RUN)) begin
          emit.item.out_byte = BYTE_FF;
          if (fire) begin
            rem_nxt    = rem_r - LEN_W'(SIZE_RUN);
            parity_nxt = ~parity_r;
          end
        end else begin
          emit.item.out_byte = rem_r[7:0];
          if (fire) begin
            parity_nxt = ~parity_r;
            cnt_nxt    = 4'd0;
            phase_nxt  = PH_UUID;
          end
        end
      end
      PH_UUID: begin
        emit.item.out_byte = uuid_all[{~cnt_r, 3'b000} +: 8];
        if (fire) begin
          cnt_nxt    = cnt_r + 4'd1;
          parity_nxt = ~parity_r;
          if (cnt_r == 4'(UUID_BYTES - 1)) begin
            if (bytes_left_r == '0) begin
              phase_nxt = parity_r ? PH_TAIL0 : PH_TAIL80;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
      PH_EPB: begin
        emit.item.out_byte = BYTE_EPB;
        if (fire) begin
          parity_nxt   = ~parity_r;
          zero_run_nxt = 2'd0;
          phase_nxt    = PH_DATA;
        end
      end
      PH_DATA: begin
        emit.item.out_byte = byte_r;
        if (fire) begin
          parity_nxt = ~parity_r;
          if (byte_r == BYTE_ZERO) begin
            zero_run_nxt = zero_run_r[1] ? zero_run_r : zero_run_r + 2'd1;
          end else begin
            zero_run_nxt = 2'd0;
          end
          bytes_left_nxt = bytes_left_r - LEN_W'(1);
          if (bytes_left_r == LEN_W'(1)) begin
            phase_nxt = parity_r ? PH_TAIL0 : PH_TAIL80;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_TAIL0: begin
        emit.item.out_byte = BYTE_ZERO;
        if (fire) begin
          phase_nxt = PH_TAIL80;
        end
      end
      PH_TAIL80: begin
        emit.item.out_byte       = BYTE_STOP;
        emit.item.last_of_packet = 1'b1;
        if (fire) begin
          open_nxt       = 1'b0;
          bytes_left_nxt = '0;
          zero_run_nxt   = 2'd0;
          parity_nxt     = 1'b0;
          phase_nxt      = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // take the next item as soon as the current one drains
    free   = (phase_r == PH_IDLE) || (fire && (phase_nxt == PH_IDLE));
    accept = in_valid && free;

    if (accept) begin
      if (in_item.kind == KIND_START) begin
        phase_nxt      = PH_SC;
        cnt_nxt        = cfg.start_code_mode ? 4'd1 : 4'd0;
        rem_nxt        = len_sat + LEN_W'(UUID_BYTES);
        bytes_left_nxt = len_sat;
        zero_run_nxt   = 2'd0;
        parity_nxt     = 1'b0;
        open_nxt       = 1'b1;
      end else if (open_nxt) begin
        byte_nxt  = in_item.data_byte;
        phase_nxt = zero_run_nxt[1] ? PH_EPB : PH_DATA;
      end
    end
  end

  assign in_stall  = !free;
  assign stat.busy = (phase_r != PH_IDLE);
  assign stat.open = open_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      cnt_r        <= 4'd0;
      rem_r        <= '0;
      bytes_left_r <= '0;
      zero_run_r   <= 2'd0;
      parity_r     <= 1'b0;
      open_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      rem_r        <= rem_nxt;
      bytes_left_r <= bytes_left_nxt;
      zero_run_r   <= zero_run_nxt;
      parity_r     <= parity_nxt;
      open_r       <= open_nxt;
    end
    byte_r <= byte_nxt;
  end

endmodule

// ===== rtl/sei_obuf.sv =====
// Output register between the byte sequencer and the result channel.
// Depends on sei_pkg.
module sei_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  sei_pkg::emit_t     emit,
  output logic               emit_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output sei_pkg::out_item_t out_item
);
  import sei_pkg::*;

  logic      out_valid_r;
  out_item_t out_item_r;

  assign emit_ready = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ready) begin
      out_valid_r <= emit.valid;
    end
    if (emit_ready && emit.valid) begin
      out_item_r <= emit.item;
    end
  end

endmodule
